// ===== hdl/multi_timer_table_top_defines.svh =====
// Assertion macros shared by the timer table RTL
`ifndef MULTI_TIMER_TABLE_TOP_DEFINES_SVH
`define MULTI_TIMER_TABLE_TOP_DEFINES_SVH
// implication assertion under synchronous reset
`define MTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication assertion
`define MTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg: timer table shared types and codes
// Command, kind and status codes plus the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package mtt_pkg;
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ADD_ONE = 3'd1;
    localparam logic [2:0] CMD_ADD_PER = 3'd2;
    localparam logic [2:0] CMD_DESTROY = 3'd3;
    localparam logic [2:0] CMD_PAUSE   = 3'd4;
    localparam logic [2:0] CMD_RESUME  = 3'd5;
    localparam logic [2:0] CMD_RESET   = 3'd6;
    localparam logic [2:0] CMD_UNUSED  = 3'd7;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_NOEXP  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // most expiries reported for one tick; further ones are applied silently
    localparam int MAX_RESULTS = 16;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] id;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

// ===== hdl/mtt_out_reg.sv =====
// ----------------------------------------------------------------------------
// mtt_out_reg: result output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_timer_table_top_defines.svh"
module mtt_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire mtt_pkg::t_result i_res,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output mtt_pkg::t_result     o_res
);
    logic             r_valid;
    mtt_pkg::t_result r_res;

    // load when empty, drain on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_full  = r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    `MTT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_load, !r_valid, "load while full")
    `MTT_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_res),
        "stalled result changed")
    `MTT_ASSERT_IMP(a_kind_ok, i_clk, i_rst_n, r_valid, r_res.kind <= mtt_pkg::KIND_NOEXP,
        "bad kind")
endmodule
`default_nettype wire

// ===== hdl/multi_timer_table_top.sv =====
// ----------------------------------------------------------------------------
// multi_timer_table_top: table of one-shot and periodic timers
// Slot sweep sequencer sharing one increment/compare unit over all slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one command transaction: cmd,
//   target_id, duration. Output channel (o_valid/i_ready) returns results:
//   kind, status, result_id, last; last marks the final result of a command.
//   Every command walks the slot table one slot per pass; each pass has a
//   read state (memory read) and an eval state (increment/compare and write
//   back). The final result is loaded into the output register after the
//   sweep, and the next command is taken once that result has entered it.
//   Each expiry is held until the next one is found, so that last lands on
//   the final one; the sweep halts while a result waits to enter a full
//   output register.
//   o_ready is high only while the sequencer is idle with nothing pending.
//   Reset clears the valid/running/periodic flags and the id counter; slot
//   ids, durations and elapsed counts are not cleared (gated by valid bits).
//   A stalled receiver holds results and stalls the sweep; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_timer_table_top_defines.svh"
module multi_timer_table_top #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [15:0] i_target_id,
    input  wire logic [31:0] i_duration,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [15:0]      o_result_id,
    output logic             o_last
);
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(mtt_pkg::MAX_RESULTS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    // flags in flops, payload in memories
    logic [NUM_SLOTS-1:0] r_valid, r_run, r_per;
    logic [15:0]          mem_id  [NUM_SLOTS];
    logic [TIME_BITS-1:0] mem_dur [NUM_SLOTS];
    logic [TIME_BITS-1:0] mem_el  [NUM_SLOTS];
    logic [15:0]          r_rd_id;
    logic [TIME_BITS-1:0] r_rd_dur, r_rd_el;

    mtt_pkg::t_state  r_state;
    logic [IW-1:0]    r_idx;
    logic [2:0]       r_cmd;
    logic [15:0]      r_tid, r_next_id;
    logic [TIME_BITS-1:0] r_dur;
    logic             r_any;
    logic             r_pend;
    mtt_pkg::t_result r_pres;
    mtt_pkg::t_result r_held;
    logic [CW-1:0]    r_cnt;

    logic             load, ofull;
    mtt_pkg::t_result ores;

    logic last_idx;
    assign last_idx = (r_idx == IW'(NUM_SLOTS - 1));

    // shared unit: saturating increment and compare
    logic [TIME_BITS-1:0] inc_el;
    logic                 expire, hit, live, rep;
    assign live   = r_valid[r_idx] && r_run[r_idx];
    assign inc_el = (r_rd_el < TMAX) ? r_rd_el + 1'b1 : r_rd_el;
    assign expire = live && (inc_el >= r_rd_dur);
    assign hit    = r_valid[r_idx] && (r_rd_id == r_tid);
    assign rep    = (r_cnt < CW'(mtt_pkg::MAX_RESULTS));

    logic [NUM_SLOTS-1:0] free_v;
    logic                 r_full_seen;
    assign free_v = ~r_valid;

    logic is_tick, is_add, is_id;
    assign is_tick = (r_cmd == mtt_pkg::CMD_TICK);
    assign is_add  = (r_cmd == mtt_pkg::CMD_ADD_ONE) || (r_cmd == mtt_pkg::CMD_ADD_PER);
    assign is_id   = !is_tick && !is_add;

    assign load   = r_pend && !ofull;
    assign ores   = r_pres;
    assign o_ready = (r_state == mtt_pkg::S_IDLE) && !r_pend;

    // payload memory: registered read, one write port
    always_ff @(posedge i_clk) begin
        r_rd_id  <= mem_id[r_idx];
        r_rd_dur <= mem_dur[r_idx];
        r_rd_el  <= mem_el[r_idx];
        if (r_state == mtt_pkg::S_EVAL && !r_pend) begin
            if (is_tick && live) begin
                mem_el[r_idx] <= expire ? '0 : inc_el;
            end else if (is_add && free_v[r_idx] && !r_full_seen) begin
                mem_id[r_idx]  <= r_next_id + 16'd1;
                mem_dur[r_idx] <= r_dur;
                mem_el[r_idx]  <= '0;
            end else if (is_id && hit && !r_full_seen && r_cmd == mtt_pkg::CMD_RESET) begin
                mem_el[r_idx]  <= '0;
                mem_dur[r_idx] <= r_dur;
            end
        end
    end

    // sequencer; r_full_seen doubles as "already done" for add and lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtt_pkg::S_IDLE;
            r_valid     <= '0;
            r_run       <= '0;
            r_per       <= '0;
            r_next_id   <= '0;
            r_pend      <= 1'b0;
            r_idx       <= '0;
            r_any       <= 1'b0;
            r_cnt       <= '0;
            r_full_seen <= 1'b0;
        end else begin
            if (load) r_pend <= 1'b0;
            unique case (r_state)
                mtt_pkg::S_IDLE: begin
                    if (i_valid && o_ready && i_cmd != mtt_pkg::CMD_UNUSED) begin
                        r_cmd       <= i_cmd;
                        r_tid       <= i_target_id;
                        r_dur       <= TIME_BITS'(i_duration);
                        r_idx       <= '0;
                        r_any       <= 1'b0;
                        r_cnt       <= '0;
                        r_full_seen <= 1'b0;
                        r_state     <= mtt_pkg::S_READ;
                    end
                end
                mtt_pkg::S_READ: r_state <= mtt_pkg::S_EVAL;
                mtt_pkg::S_EVAL: begin
                    if (!r_pend) begin
                        if (is_tick && live && expire) begin
                            if (!r_per[r_idx]) r_valid[r_idx] <= 1'b0;
                            // send the held expiry, hold this one
                            if (rep) begin
                                r_cnt  <= r_cnt + 1'b1;
                                r_any  <= 1'b1;
                                r_pend <= r_any;
                                r_pres <= r_held;
                                r_held <= '{mtt_pkg::KIND_EXPIRY, mtt_pkg::ST_OK,
                                            r_rd_id, 1'b0};
                            end
                        end else if (is_add && free_v[r_idx] && !r_full_seen) begin
                            r_full_seen       <= 1'b1;
                            r_valid[r_idx]    <= 1'b1;
                            r_run[r_idx]      <= 1'b1;
                            r_per[r_idx]      <= (r_cmd == mtt_pkg::CMD_ADD_PER);
                            r_next_id         <= r_next_id + 16'd1;
                            r_pres <= '{mtt_pkg::KIND_STATUS, mtt_pkg::ST_OK,
                                        r_next_id + 16'd1, 1'b1};
                        end else if (is_id && hit && !r_full_seen) begin
                            r_full_seen <= 1'b1;
                            if (r_cmd == mtt_pkg::CMD_DESTROY) r_valid[r_idx] <= 1'b0;
                            if (r_cmd == mtt_pkg::CMD_PAUSE)   r_run[r_idx] <= 1'b0;
                            if (r_cmd == mtt_pkg::CMD_RESUME)  r_run[r_idx] <= 1'b1;
                            r_pres <= '{mtt_pkg::KIND_STATUS, mtt_pkg::ST_OK, r_tid, 1'b1};
                        end
                        if (last_idx) begin
                            r_state <= mtt_pkg::S_OUT;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= mtt_pkg::S_READ;
                        end
                    end
                end
                mtt_pkg::S_OUT: begin
                    if (!r_pend) begin
                        r_pend  <= 1'b1;
                        r_state <= mtt_pkg::S_IDLE;
                        if (is_tick) begin
                            // final held expiry goes out with last set
                            if (r_any)
                                r_pres <= '{r_held.kind, r_held.status, r_held.id, 1'b1};
                            else
                                r_pres <= '{mtt_pkg::KIND_NOEXP, mtt_pkg::ST_OK, 16'd0, 1'b1};
                        end else if (!r_full_seen) begin
                            if (is_add)
                                r_pres <= '{mtt_pkg::KIND_STATUS, mtt_pkg::ST_FULL, 16'd0, 1'b1};
                            else
                                r_pres <= '{mtt_pkg::KIND_STATUS, mtt_pkg::ST_NOTFOUND,
                                            r_tid, 1'b1};
                        end
                    end
                end
                default: r_state <= mtt_pkg::S_IDLE;
            endcase
        end
    end

    mtt_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (load),
        .i_res  (ores),
        .o_full (ofull),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_res  ({o_kind, o_status, o_result_id, o_last})
    );

    `MTT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == mtt_pkg::S_IDLE,
        "ready outside idle")
    `MTT_ASSERT_NXT(a_accept, i_clk, i_rst_n, i_valid && o_ready && i_cmd != mtt_pkg::CMD_UNUSED,
        r_state == mtt_pkg::S_READ, "accepted command not started")
    `MTT_ASSERT_IMP(a_idx, i_clk, i_rst_n, r_state != mtt_pkg::S_IDLE,
        r_idx <= IW'(NUM_SLOTS - 1), "slot index out of range")
endmodule
`default_nettype wire

// ===== dv/multi_timer_table_checker.sv =====
// ----------------------------------------------------------------------------
// multi_timer_table_checker: prediction and compare for the timer table
// Watches the command and result channels, keeps its own copy of the slot
// table, works out the results of each accepted command and compares them,
// in order, with the results that the block returns.
// ----------------------------------------------------------------------------
module multi_timer_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_target_id,
    input  logic [31:0] i_duration,
    input  logic        i_valid_out,
    input  logic        i_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_result_id,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // Model of the slot table
    logic        tbl_valid   [SLOTS];
    logic        tbl_running [SLOTS];
    logic        tbl_periodic[SLOTS];
    logic [15:0] tbl_id      [SLOTS];
    logic [31:0] tbl_dur     [SLOTS];
    logic [31:0] tbl_elapsed [SLOTS];
    logic [15:0] id_counter;

    mtt_pkg::t_result expected_results[$];
    int      mismatch_count;

    assign o_errors  = mismatch_count;

    function automatic mtt_pkg::t_result mk(logic [1:0] k, logic [1:0] s, logic [15:0] id,
                                            logic l);
        mtt_pkg::t_result r;
        r.kind = k; r.status = s; r.id = id; r.last = l;
        return r;
    endfunction

    // Apply one command to the table and queue what it should return
    task automatic predict_command(logic [2:0] cmd, logic [15:0] tid, logic [31:0] dur);
        int n;
        int hit;
        n = 0;
        hit = -1;
        case (cmd)
            mtt_pkg::CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_running[i]) begin
                        if (tbl_elapsed[i] != TIME_MAX) tbl_elapsed[i]++;
                        if (tbl_elapsed[i] >= tbl_dur[i]) begin
                            expected_results.push_back(mk(mtt_pkg::KIND_EXPIRY,
                                                          mtt_pkg::ST_OK, tbl_id[i], 1'b0));
                            n++;
                            if (tbl_periodic[i]) tbl_elapsed[i] = '0;
                            else tbl_valid[i] = 1'b0;
                        end
                    end
                end
                if (n == 0)
                    expected_results.push_back(mk(mtt_pkg::KIND_NOEXP, mtt_pkg::ST_OK,
                                                  16'd0, 1'b1));
                else expected_results[$].last = 1'b1;
            end
            mtt_pkg::CMD_ADD_ONE, mtt_pkg::CMD_ADD_PER: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tbl_valid[i]) hit = i;
                if (hit < 0) begin
                    expected_results.push_back(mk(mtt_pkg::KIND_STATUS, mtt_pkg::ST_FULL,
                                                  16'd0, 1'b1));
                end else begin
                    id_counter++;
                    tbl_valid[hit]    = 1'b1;
                    tbl_running[hit]  = 1'b1;
                    tbl_periodic[hit] = (cmd == mtt_pkg::CMD_ADD_PER);
                    tbl_id[hit]       = id_counter;
                    tbl_dur[hit]      = dur;
                    tbl_elapsed[hit]  = '0;
                    expected_results.push_back(mk(mtt_pkg::KIND_STATUS, mtt_pkg::ST_OK,
                                                  id_counter, 1'b1));
                end
            end
            mtt_pkg::CMD_DESTROY, mtt_pkg::CMD_PAUSE, mtt_pkg::CMD_RESUME,
            mtt_pkg::CMD_RESET: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_valid[i] && tbl_id[i] == tid) hit = i;
                if (hit < 0) begin
                    expected_results.push_back(mk(mtt_pkg::KIND_STATUS, mtt_pkg::ST_NOTFOUND,
                                                  tid, 1'b1));
                end else begin
                    case (cmd)
                        mtt_pkg::CMD_DESTROY: tbl_valid[hit] = 1'b0;
                        mtt_pkg::CMD_PAUSE:   tbl_running[hit] = 1'b0;
                        mtt_pkg::CMD_RESUME:  tbl_running[hit] = 1'b1;
                        default: begin
                            tbl_elapsed[hit] = '0;
                            tbl_dur[hit]     = dur;
                        end
                    endcase
                    expected_results.push_back(mk(mtt_pkg::KIND_STATUS, mtt_pkg::ST_OK,
                                                  tid, 1'b1));
                end
            end
            default: ;  // unknown command: no effect, no result
        endcase
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        mtt_pkg::t_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                tbl_valid[i] = 1'b0; tbl_running[i] = 1'b0; tbl_periodic[i] = 1'b0;
                tbl_id[i] = '0; tbl_dur[i] = '0; tbl_elapsed[i] = '0;
            end
            id_counter = '0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (i_valid_out && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d status=%0d id=%0d last=%0d",
                             $time, i_kind, i_status, i_result_id, i_last);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.kind !== i_kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, i_kind);
                        mismatch_count++;
                    end
                    if (exp_r.status !== i_status) begin
                        $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                                 i_status);
                        mismatch_count++;
                    end
                    if (exp_r.id !== i_result_id) begin
                        $display("%0t: result_id expected %0d actual %0d", $time, exp_r.id,
                                 i_result_id);
                        mismatch_count++;
                    end
                    if (exp_r.last !== i_last) begin
                        $display("%0t: last expected %0d actual %0d", $time, exp_r.last, i_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && i_ready_in) predict_command(i_cmd, i_target_id, i_duration);
        end
        o_pending = expected_results.size();
    end
endmodule

// ===== dv/multi_timer_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// multi_timer_table_top_tb: command stimulus for the timer table
// Directed commands over every operation and corner, then random streams of
// adds, ticks and lookups with random gaps on both channels; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module multi_timer_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [2:0]  cmd;
    logic [15:0] target_id;
    logic [31:0] duration;
    logic        res_valid;
    logic        res_ready;
    logic        rx_ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic        last;
    int          errors;
    int          pending;
    int          cycle_count;
    logic        hold_req;
    logic        long_hold;

    // Ids handed out so far, for lookups that hit
    logic [15:0] issued_ids[$];

    multi_timer_table_top DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(cmd_valid), .o_ready(cmd_ready),
        .i_cmd(cmd), .i_target_id(target_id), .i_duration(duration),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_kind(kind), .o_status(status), .o_result_id(result_id), .o_last(last)
    );

    multi_timer_table_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(cmd_valid), .i_ready_in(cmd_ready),
        .i_cmd(cmd), .i_target_id(target_id), .i_duration(duration),
        .i_valid_out(res_valid), .i_ready(res_ready),
        .i_kind(kind), .i_status(status), .i_result_id(result_id), .i_last(last),
        .o_errors(errors), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_timer_table_top_tb failed");
            $finish;
        end
    end

    // Track ids returned in OK status results, adds and lookup hits alike
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready && kind == mtt_pkg::KIND_STATUS
            && status == mtt_pkg::ST_OK && issued_ids.size() < 64)
            issued_ids.push_back(result_id);
    end

    assign res_ready = rx_ready && !long_hold;

    // Long receiver hold-off, counted in cycles once requested
    initial begin
        long_hold = 1'b0;
        wait (hold_req);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (400) @(negedge clk);
        long_hold <= 1'b0;
    end

    // Receiver: random stalls per result
    initial begin
        int gap;
        rx_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                rx_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rx_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && res_ready));
        end
    end

    task automatic send(logic [2:0] c, logic [15:0] t, logic [31:0] d, int gap);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        target_id <= t;
        duration  <= d;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_id();
        if (issued_ids.size() > 0 && $urandom_range(0, 4) != 0)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        return 16'($urandom());
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic drain();
        cmd_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    initial begin
        int r;
        logic [2:0]  c;
        logic [31:0] d;
        cycle_count = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = mtt_pkg::CMD_TICK;
        target_id = '0;
        duration = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty tick, misses, zero and max durations, all operations
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_DESTROY, 16'hFFFF, 32'd0, 0);
        send(mtt_pkg::CMD_ADD_ONE, 16'd0, 32'd0, 0);            // expires on first tick
        send(mtt_pkg::CMD_ADD_PER, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send(mtt_pkg::CMD_ADD_PER, 16'd0, 32'd1, 1);
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_PAUSE, 16'd3, 32'd0, 0);
        send(mtt_pkg::CMD_PAUSE, 16'd3, 32'd0, 0);              // already paused
        send(mtt_pkg::CMD_RESUME, 16'd2, 32'd0, 0);             // already running
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_RESUME, 16'd3, 32'd0, 2);
        send(mtt_pkg::CMD_RESET, 16'd2, 32'd2, 0);
        send(mtt_pkg::CMD_RESET, 16'd9, 32'hAAAA_5555, 0);
        send(mtt_pkg::CMD_UNUSED, 16'h5555, 32'h5555_AAAA, 0);  // unknown command
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_DESTROY, 16'd2, 32'd0, 0);
        send(mtt_pkg::CMD_DESTROY, 16'd3, 32'd0, 0);
        // fill the table with zero-length periodics and overflow it once; later ticks fire them all
        for (int i = 0; i < 17; i++) send(mtt_pkg::CMD_ADD_PER, 16'd0, 32'd0, 0);
        drain();

        // Long receiver hold with the sender still pushing
        hold_req = 1'b1;
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        send(mtt_pkg::CMD_TICK, 16'd0, 32'd0, 0);
        for (int i = 0; i < 16; i++) send(mtt_pkg::CMD_DESTROY, 16'(i + 3), 32'd0, 0);
        drain();

        // Random part: mostly ticks and adds with short durations
        for (int n = 0; n < 406; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) c = mtt_pkg::CMD_TICK;
            else if (r < 50) c = mtt_pkg::CMD_ADD_ONE;
            else if (r < 62) c = mtt_pkg::CMD_ADD_PER;
            else if (r < 72) c = mtt_pkg::CMD_DESTROY;
            else if (r < 80) c = mtt_pkg::CMD_PAUSE;
            else if (r < 88) c = mtt_pkg::CMD_RESUME;
            else if (r < 97) c = mtt_pkg::CMD_RESET;
            else c = mtt_pkg::CMD_UNUSED;
            d = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 6));
            send(c, pick_id(), d, pick_gap());
            if (n == 200) drain();
        end
        drain();

        if (errors == 0)
            $display("multi_timer_table_top_tb passed");
        else
            $display("multi_timer_table_top_tb failed");
        $finish;
    end
endmodule
